// ===== rtl/roi_bilinear_resample_assert.svh =====
// assertion macros used by the checker file
`ifndef ROI_BILINEAR_RESAMPLE_ASSERT_SVH
`define ROI_BILINEAR_RESAMPLE_ASSERT_SVH

// same-cycle implication
`define RBR_ASSERT_NOW(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBR_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rbr_pkg;

    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 64;
    localparam int MAX_CHANNELS = 16;
    localparam int FRAC_BITS    = 16;

    localparam int CHAN_W  = 4;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int CNT_W   = 5;
    localparam int SMP_W   = 16;
    localparam int CFG_AW  = 3;

    // reciprocal scaling for the position divide
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_N     = 1 << SIZE_W;
    localparam int M_W         = ROW_W + ROW_W;
    localparam int NUM_W       = M_W + FRAC_BITS;
    localparam int Q_W         = ROW_W + FRAC_BITS;
    localparam int QD_W        = NUM_W + 1;

    // four banks split on row and column parity
    localparam int BANK_AW    = CHAN_W + ROW_W - 1 + COL_W - 1;
    localparam int BANK_DEPTH = MAX_CHANNELS * MAX_ROWS * MAX_COLS / 4;

    // blend arithmetic widths
    localparam int W_W   = FRAC_BITS + 2;
    localparam int P_W   = W_W + SMP_W;
    localparam int S_W   = P_W + 1;
    localparam int WP_W  = W_W + S_W;
    localparam int SUM_W = WP_W + 1;
    localparam int RND_SH = 2 * FRAC_BITS;
    localparam int RES_W  = SUM_W - RND_SH;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    typedef enum logic [CFG_AW-1:0] {
        CFG_MAP_H    = 3'd0,
        CFG_MAP_W    = 3'd1,
        CFG_OUT_H    = 3'd2,
        CFG_OUT_W    = 3'd3,
        CFG_CHAN_CNT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [SIZE_W-1:0] map_h;
        logic [SIZE_W-1:0] map_w;
        logic [SIZE_W-1:0] out_h;
        logic [SIZE_W-1:0] out_w;
        logic [CNT_W-1:0]  chan_cnt;
    } t_cfg;

    typedef struct packed {
        logic              mode;
        logic [CHAN_W-1:0] chan;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SMP_W-1:0]  sample;
        logic [SIZE_W-1:0] x_start;
        logic [SIZE_W-1:0] y_start;
        logic [SIZE_W-1:0] x_end;
        logic [SIZE_W-1:0] y_end;
    } t_item;

    // store access request: a load write or a four-neighbor read
    typedef struct packed {
        logic                 vld;
        logic                 res;
        logic                 err;
        logic                 we;
        logic [CHAN_W-1:0]    chan;
        logic [ROW_W-1:0]     y0;
        logic [COL_W-1:0]     x0;
        logic                 dy;
        logic                 dx;
        logic [FRAC_BITS-1:0] fy;
        logic [FRAC_BITS-1:0] fx;
        logic [SMP_W-1:0]     wdata;
    } t_req;

    // four neighbors with their weights
    typedef struct packed {
        logic                 vld;
        logic                 err;
        logic [FRAC_BITS-1:0] fy;
        logic [FRAC_BITS-1:0] fx;
        logic [SMP_W-1:0]     s00;
        logic [SMP_W-1:0]     s01;
        logic [SMP_W-1:0]     s10;
        logic [SMP_W-1:0]     s11;
    } t_tap;

endpackage
`default_nettype wire

// ===== rtl/rbr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/rbr_pos.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbr_pos import rbr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_adv,
    input  wire logic  i_acc,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_req       o_req
);

    // reciprocal table floor(2^28 / d)
    logic [RECIP_W-1:0] w_recip [RECIP_N];
    for (genvar g = 0; g < RECIP_N; g++) begin : g_recip
        if (g == 0) begin : g_zero
            assign w_recip[g] = '0;
        end else begin : g_div
            localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / g);
            assign w_recip[g] = RECIP;
        end
    end

    // stage 1: range checks, scaled index, reciprocal lookup
    logic [SIZE_W-1:0] n_mh, n_mw, n_rh, n_rw, n_rhm1, n_rwm1, n_dy, n_dx;
    logic [CNT_W-1:0]  n_nc;
    logic              n_err, n_we;
    logic [M_W-1:0]    n_my, n_mx;

    always_comb begin
        n_mh = (i_cfg.map_h > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : i_cfg.map_h;
        n_mw = (i_cfg.map_w > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : i_cfg.map_w;
        n_nc = (i_cfg.chan_cnt > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                        : i_cfg.chan_cnt;
        n_err = (i_item.x_end > n_mw) || (i_item.y_end > n_mh)
             || (i_item.x_start >= i_item.x_end) || (i_item.y_start >= i_item.y_end)
             || ({1'b0, i_item.chan} >= n_nc)
             || ({1'b0, i_item.row} >= i_cfg.out_h)
             || ({1'b0, i_item.col} >= i_cfg.out_w);
        n_we = (i_item.mode == MODE_LOAD) && ({1'b0, i_item.chan} < n_nc)
            && ({1'b0, i_item.row} < n_mh) && ({1'b0, i_item.col} < n_mw);
        n_rh   = i_item.y_end - i_item.y_start;
        n_rw   = i_item.x_end - i_item.x_start;
        n_rhm1 = n_rh - SIZE_W'(1);
        n_rwm1 = n_rw - SIZE_W'(1);
        n_my   = n_rhm1[ROW_W-1:0] * i_item.row;
        n_mx   = n_rwm1[COL_W-1:0] * i_item.col;
        n_dy   = i_cfg.out_h - SIZE_W'(1);
        n_dx   = i_cfg.out_w - SIZE_W'(1);
    end

    logic                r1_vld, r1_res, r1_err, r1_we;
    logic [CHAN_W-1:0]   r1_chan;
    logic [ROW_W-1:0]    r1_row;
    logic [COL_W-1:0]    r1_col;
    logic [SMP_W-1:0]    r1_wdata;
    logic [SIZE_W-1:0]   r1_xs, r1_ys, r1_rh, r1_rw, r1_dy, r1_dx;
    logic [M_W-1:0]      r1_my, r1_mx;
    logic [RECIP_W-1:0]  r1_ry, r1_rx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_adv) begin
            r1_vld <= i_acc;
        end
        if (i_adv) begin
            r1_res   <= (i_item.mode == MODE_SAMPLE);
            r1_err   <= n_err;
            r1_we    <= n_we;
            r1_chan  <= i_item.chan;
            r1_row   <= i_item.row;
            r1_col   <= i_item.col;
            r1_wdata <= i_item.sample;
            r1_xs    <= i_item.x_start;
            r1_ys    <= i_item.y_start;
            r1_rh    <= n_rh;
            r1_rw    <= n_rw;
            r1_dy    <= n_dy;
            r1_dx    <= n_dx;
            r1_my    <= n_my;
            r1_mx    <= n_mx;
            r1_ry    <= w_recip[n_dy];
            r1_rx    <= w_recip[n_dx];
        end
    end

    // stage 2: quotient estimate by reciprocal multiply
    logic [M_W+RECIP_W-1:0] n_py, n_px;
    assign n_py = r1_my * r1_ry;
    assign n_px = r1_mx * r1_rx;

    logic                r2_vld, r2_res, r2_err, r2_we;
    logic [CHAN_W-1:0]   r2_chan;
    logic [ROW_W-1:0]    r2_row;
    logic [COL_W-1:0]    r2_col;
    logic [SMP_W-1:0]    r2_wdata;
    logic [SIZE_W-1:0]   r2_xs, r2_ys, r2_rh, r2_rw, r2_dy, r2_dx;
    logic [M_W-1:0]      r2_my, r2_mx;
    logic [Q_W-1:0]      r2_qy, r2_qx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_adv) begin
            r2_vld <= r1_vld;
        end
        if (i_adv) begin
            r2_res   <= r1_res;
            r2_err   <= r1_err;
            r2_we    <= r1_we;
            r2_chan  <= r1_chan;
            r2_row   <= r1_row;
            r2_col   <= r1_col;
            r2_wdata <= r1_wdata;
            r2_xs    <= r1_xs;
            r2_ys    <= r1_ys;
            r2_rh    <= r1_rh;
            r2_rw    <= r1_rw;
            r2_dy    <= r1_dy;
            r2_dx    <= r1_dx;
            r2_my    <= r1_my;
            r2_mx    <= r1_mx;
            r2_qy    <= n_py[RECIP_SHIFT-FRAC_BITS +: Q_W];
            r2_qx    <= n_px[RECIP_SHIFT-FRAC_BITS +: Q_W];
        end
    end

    // stage 3: remainder check lifts the estimate by one where short
    logic [QD_W-1:0] n_qdy, n_qdx, n_remy, n_remx;
    logic            n_incy, n_incx;

    always_comb begin
        n_qdy  = QD_W'(r2_qy * r2_dy);
        n_qdx  = QD_W'(r2_qx * r2_dx);
        n_remy = QD_W'({r2_my, {FRAC_BITS{1'b0}}}) - n_qdy;
        n_remx = QD_W'({r2_mx, {FRAC_BITS{1'b0}}}) - n_qdx;
        n_incy = (r2_dy != '0) && (n_remy >= QD_W'(r2_dy));
        n_incx = (r2_dx != '0) && (n_remx >= QD_W'(r2_dx));
    end

    logic                r3_vld, r3_res, r3_err, r3_we;
    logic [CHAN_W-1:0]   r3_chan;
    logic [ROW_W-1:0]    r3_row;
    logic [COL_W-1:0]    r3_col;
    logic [SMP_W-1:0]    r3_wdata;
    logic [SIZE_W-1:0]   r3_xs, r3_ys, r3_rh, r3_rw;
    logic [Q_W-1:0]      r3_qy, r3_qx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_adv) begin
            r3_vld <= r2_vld;
        end
        if (i_adv) begin
            r3_res   <= r2_res;
            r3_err   <= r2_err;
            r3_we    <= r2_we;
            r3_chan  <= r2_chan;
            r3_row   <= r2_row;
            r3_col   <= r2_col;
            r3_wdata <= r2_wdata;
            r3_xs    <= r2_xs;
            r3_ys    <= r2_ys;
            r3_rh    <= r2_rh;
            r3_rw    <= r2_rw;
            r3_qy    <= r2_qy + Q_W'(n_incy);
            r3_qx    <= r2_qx + Q_W'(n_incx);
        end
    end

    // stage 4: integer part, edge clamp, store coordinates
    logic [SIZE_W-1:0] n_iy, n_ix, n_y0, n_x0;
    t_req              n_req, r_req;

    always_comb begin
        n_iy = SIZE_W'(r3_qy[Q_W-1:FRAC_BITS]);
        n_ix = SIZE_W'(r3_qx[Q_W-1:FRAC_BITS]);
        n_y0 = r3_ys + n_iy;
        n_x0 = r3_xs + n_ix;
        n_req.vld   = r3_vld;
        n_req.res   = r3_res;
        n_req.err   = r3_err;
        n_req.we    = r3_we && !r3_res;
        n_req.chan  = r3_chan;
        n_req.y0    = r3_res ? n_y0[ROW_W-1:0] : r3_row;
        n_req.x0    = r3_res ? n_x0[COL_W-1:0] : r3_col;
        n_req.dy    = (n_iy + SIZE_W'(1)) < r3_rh;
        n_req.dx    = (n_ix + SIZE_W'(1)) < r3_rw;
        n_req.fy    = r3_qy[FRAC_BITS-1:0];
        n_req.fx    = r3_qx[FRAC_BITS-1:0];
        n_req.wdata = r3_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.vld <= 1'b0;
        end else if (i_adv) begin
            r_req.vld <= n_req.vld;
        end
        if (i_adv) begin
            r_req.res   <= n_req.res;
            r_req.err   <= n_req.err;
            r_req.we    <= n_req.we;
            r_req.chan  <= n_req.chan;
            r_req.y0    <= n_req.y0;
            r_req.x0    <= n_req.x0;
            r_req.dy    <= n_req.dy;
            r_req.dx    <= n_req.dx;
            r_req.fy    <= n_req.fy;
            r_req.fx    <= n_req.fx;
            r_req.wdata <= n_req.wdata;
        end
    end

    assign o_req = r_req;

endmodule
`default_nettype wire

// ===== rtl/rbr_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbr_store import rbr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_adv,
    input  wire t_req i_req,
    output t_tap      o_tap
);

    // half-resolution row and column for even and odd banks
    logic [ROW_W:0]   w_y1;
    logic [COL_W:0]   w_x1;
    logic [ROW_W-2:0] w_yh [2];
    logic [COL_W-2:0] w_xh [2];
    logic [SMP_W-1:0] w_bank [4];

    assign w_y1    = {1'b0, i_req.y0} + (ROW_W+1)'(1);
    assign w_x1    = {1'b0, i_req.x0} + (COL_W+1)'(1);
    assign w_yh[0] = w_y1[ROW_W-1:1];
    assign w_yh[1] = i_req.y0[ROW_W-1:1];
    assign w_xh[0] = w_x1[COL_W-1:1];
    assign w_xh[1] = i_req.x0[COL_W-1:1];

    // one bank per row parity and column parity
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic ROW_P = 1'((b >> 1) & 1);
        localparam logic COL_P = 1'(b & 1);
        logic               w_we;
        logic [BANK_AW-1:0] w_waddr, w_raddr;
        assign w_we = i_adv && i_req.vld && i_req.we
                   && (i_req.y0[0] == ROW_P) && (i_req.x0[0] == COL_P);
        assign w_waddr = {i_req.chan, i_req.y0[ROW_W-1:1], i_req.x0[COL_W-1:1]};
        assign w_raddr = {i_req.chan, w_yh[ROW_P], w_xh[COL_P]};
        rbr_ram #(
            .WIDTH (SMP_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (w_waddr),
            .i_wdata (i_req.wdata),
            .i_re    (i_adv),
            .i_raddr (w_raddr),
            .o_rdata (w_bank[b])
        );
    end

    // request fields kept in step with the read data
    logic                 r_vld, r_err, r_dy, r_dx, r_yp, r_xp;
    logic [FRAC_BITS-1:0] r_fy, r_fx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_req.vld && i_req.res;
        end
        if (i_adv) begin
            r_err <= i_req.err;
            r_dy  <= i_req.dy;
            r_dx  <= i_req.dx;
            r_yp  <= i_req.y0[0];
            r_xp  <= i_req.x0[0];
            r_fy  <= i_req.fy;
            r_fx  <= i_req.fx;
        end
    end

    // steer banks to the four neighbors
    always_comb begin
        o_tap.vld = r_vld;
        o_tap.err = r_err;
        o_tap.fy  = r_fy;
        o_tap.fx  = r_fx;
        o_tap.s00 = w_bank[{r_yp, r_xp}];
        o_tap.s01 = w_bank[{r_yp, r_xp ^ r_dx}];
        o_tap.s10 = w_bank[{r_yp ^ r_dy, r_xp}];
        o_tap.s11 = w_bank[{r_yp ^ r_dy, r_xp ^ r_dx}];
    end

endmodule
`default_nettype wire

// ===== rtl/rbr_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rbr_blend import rbr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire t_tap              i_tap,
    output logic                   o_vld,
    output logic [SMP_W-1:0]       o_value,
    output logic                   o_err
);

    localparam logic [W_W-1:0] ONE = W_W'(1 << FRAC_BITS);

    // horizontal weighted products
    logic signed [W_W-1:0] n_gx, n_fx;
    assign n_gx = $signed(ONE - W_W'(i_tap.fx));
    assign n_fx = $signed(W_W'(i_tap.fx));

    logic                    r5_vld, r5_err;
    logic [FRAC_BITS-1:0]    r5_fy;
    logic signed [P_W-1:0]   r5_p00, r5_p01, r5_p10, r5_p11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_adv) begin
            r5_vld <= i_tap.vld;
        end
        if (i_adv) begin
            r5_err <= i_tap.err;
            r5_fy  <= i_tap.fy;
            r5_p00 <= n_gx * $signed(i_tap.s00);
            r5_p01 <= n_fx * $signed(i_tap.s01);
            r5_p10 <= n_gx * $signed(i_tap.s10);
            r5_p11 <= n_fx * $signed(i_tap.s11);
        end
    end

    // row sums
    logic                    r6_vld, r6_err;
    logic [FRAC_BITS-1:0]    r6_fy;
    logic signed [S_W-1:0]   r6_top, r6_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (i_adv) begin
            r6_vld <= r5_vld;
        end
        if (i_adv) begin
            r6_err <= r5_err;
            r6_fy  <= r5_fy;
            r6_top <= S_W'(r5_p00) + S_W'(r5_p01);
            r6_bot <= S_W'(r5_p10) + S_W'(r5_p11);
        end
    end

    // vertical weighted products
    logic signed [W_W-1:0] n_gy, n_fy;
    assign n_gy = $signed(ONE - W_W'(r6_fy));
    assign n_fy = $signed(W_W'(r6_fy));

    logic                    r7_vld, r7_err;
    logic signed [WP_W-1:0]  r7_wt, r7_wb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (i_adv) begin
            r7_vld <= r6_vld;
        end
        if (i_adv) begin
            r7_err <= r6_err;
            r7_wt  <= n_gy * r6_top;
            r7_wb  <= n_fy * r6_bot;
        end
    end

    // round half up, then saturate to the sample range; an error beat gives zero
    logic signed [SUM_W-1:0] n_sum;
    logic signed [RES_W-1:0] n_res;
    logic [SMP_W-1:0]        n_value;

    always_comb begin
        n_sum = SUM_W'(r7_wt) + SUM_W'(r7_wb) + SUM_W'(64'd1 << (RND_SH - 1));
        n_res = RES_W'(n_sum >>> RND_SH);
        if (n_res > RES_W'(32767)) begin
            n_value = 16'h7FFF;
        end else if (n_res < -RES_W'(32768)) begin
            n_value = 16'h8000;
        end else begin
            n_value = n_res[SMP_W-1:0];
        end
        if (r7_err) begin
            n_value = '0;
        end
    end

    // output register
    logic             r_vld, r_err;
    logic [SMP_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= r7_vld;
        end
        if (i_adv) begin
            r_err   <= r7_err;
            r_value <= n_value;
        end
    end

    assign o_vld   = r_vld;
    assign o_err   = r_err;
    assign o_value = r_value;

endmodule
`default_nettype wire

// ===== rtl/roi_bilinear_resample.sv =====
// a sample beat passes the position, store read and blend registers to reach the output
// one beat per cycle when not stalled; four parity banks give all four neighbors in one read
// a stalled output holds every stage, so input ready follows output ready
// reset clears the stage valid bits and loads the register defaults
// the sample store is not cleared; entries are valid once loaded
`timescale 1ns / 1ps
`default_nettype none
module roi_bilinear_resample import rbr_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // chan, row, col, sample, roi_x_start, roi_y_start, roi_x_end, roi_y_end, pad
    input  wire logic [63:0]       i_s_tdata,
    // mode
    input  wire logic [0:0]        i_s_tuser,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // out_value
    output logic [15:0]            o_m_tdata,
    // roi_error
    output logic [0:0]             o_m_tuser,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [SIZE_W-1:0] i_cfg_wdata
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_h    <= SIZE_W'(64);
            r_cfg.map_w    <= SIZE_W'(64);
            r_cfg.out_h    <= SIZE_W'(7);
            r_cfg.out_w    <= SIZE_W'(7);
            r_cfg.chan_cnt <= CNT_W'(16);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_MAP_H:    r_cfg.map_h    <= i_cfg_wdata;
                CFG_MAP_W:    r_cfg.map_w    <= i_cfg_wdata;
                CFG_OUT_H:    r_cfg.out_h    <= i_cfg_wdata;
                CFG_OUT_W:    r_cfg.out_w    <= i_cfg_wdata;
                CFG_CHAN_CNT: r_cfg.chan_cnt <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // unpack the input beat
    t_item w_item;
    assign w_item.mode    = i_s_tuser[0];
    assign w_item.chan    = i_s_tdata[3:0];
    assign w_item.row     = i_s_tdata[9:4];
    assign w_item.col     = i_s_tdata[15:10];
    assign w_item.sample  = i_s_tdata[31:16];
    assign w_item.x_start = i_s_tdata[38:32];
    assign w_item.y_start = i_s_tdata[45:39];
    assign w_item.x_end   = i_s_tdata[52:46];
    assign w_item.y_end   = i_s_tdata[59:53];

    // whole pipeline moves when the output slot is free or drained
    logic w_adv, w_out_vld, w_out_err;
    logic [SMP_W-1:0] w_out_value;
    t_req w_req;
    t_tap w_tap;

    assign w_adv = !w_out_vld || i_m_tready;

    rbr_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_acc   (i_s_tvalid),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_req   (w_req)
    );

    rbr_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_req   (w_req),
        .o_tap   (w_tap)
    );

    rbr_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tap   (w_tap),
        .o_vld   (w_out_vld),
        .o_value (w_out_value),
        .o_err   (w_out_err)
    );

    assign o_s_tready   = w_adv;
    assign o_m_tvalid   = w_out_vld;
    assign o_m_tdata    = w_out_value;
    assign o_m_tuser[0] = w_out_err;

endmodule
`default_nettype wire

// ===== rtl/rbr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "roi_bilinear_resample_assert.svh"
module rbr_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_s_tready,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [15:0]       o_m_tdata,
    input wire logic [0:0]        o_m_tuser
);

    // a held output beat keeps its payload
    `RBR_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "output beat changed while stalled")

    // an error beat carries a zero value
    `RBR_ASSERT_NOW(a_err_zero, i_clk, !i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tdata == 16'h0000, "error beat with nonzero value")

    // an empty output slot never blocks the input
    `RBR_ASSERT_NOW(a_ready_free, i_clk, !i_rst_n, !o_m_tvalid, o_s_tready, "input stalled with empty output")

    // reset leaves no beat on the output
    `RBR_ASSERT_NEXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !o_m_tvalid, "output valid right after reset")

endmodule

bind roi_bilinear_resample rbr_checker u_rbr_checker (.*);
`default_nettype wire

// ===== sim/tb_roi_bilinear_resample.sv =====
`timescale 1ns / 1ps
module tb_roi_bilinear_resample;
    import rbr_pkg::*;

    typedef struct {
        bit        mode;
        bit [3:0]  chan;
        bit [5:0]  row;
        bit [5:0]  col;
        bit [15:0] smp;
        bit [6:0]  xs;
        bit [6:0]  ys;
        bit [6:0]  xe;
        bit [6:0]  ye;
    } t_beat;

    typedef struct {
        bit [15:0] value;
        bit        err;
    } t_result;

    typedef struct {
        t_beat     beat;
        bit        typed;
        bit [15:0] value;
        bit        err;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    // chan, row, col, sample, roi_x_start, roi_y_start, roi_x_end, roi_y_end, pad
    logic [63:0]       i_s_tdata;
    // mode
    logic [0:0]        i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    // out_value
    logic [15:0]       o_m_tdata;
    // roi_error
    logic [0:0]        o_m_tuser;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [SIZE_W-1:0] i_cfg_wdata;

    roi_bilinear_resample dut (.*);

    // shadow registers and store copy
    int unsigned cfg_mh = 64, cfg_mw = 64, cfg_oh = 7, cfg_ow = 7, cfg_cc = 16;
    logic signed [15:0] feature_mem [65536];
    bit                 feature_set [65536];
    t_result            pending_values[$];
    int                 fail_count = 0;
    int                 snd_idle = 0;
    int                 rcv_idle = 0;
    int                 quiet_cycles = 0;

    // clock and reset
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_m_tready  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
    end

    function automatic int unsigned cap(int unsigned v, int unsigned lim);
        return v > lim ? lim : v;
    endfunction

    function automatic int cell_addr(int unsigned c, int unsigned y, int unsigned x);
        return (c * 64 + y) * 64 + x;
    endfunction

    // expected output of one sample beat; miss is the first unloaded neighbor or -1
    function automatic void resample_value(input t_beat b, output bit [15:0] value,
                                           output bit err, output int miss);
        int unsigned mh, mw, nc, rh, rw, iy, ix, dy, dx, y0, x0;
        longint unsigned py, px;
        longint fy, fx, gy, gx, top, bot, sum, r;
        int a [4];
        mh = cap(cfg_mh, 64);
        mw = cap(cfg_mw, 64);
        nc = cap(cfg_cc, 16);
        miss = -1;
        value = '0;
        err = 1'b1;
        if (b.xe > mw || b.ye > mh || b.xs >= b.xe || b.ys >= b.ye ||
            b.chan >= nc || b.row >= cfg_oh || b.col >= cfg_ow)
            return;
        err = 1'b0;
        rh = b.ye - b.ys;
        rw = b.xe - b.xs;
        py = (cfg_oh <= 1) ? 0 : ((longint'(rh - 1) * b.row) << 16) / (cfg_oh - 1);
        px = (cfg_ow <= 1) ? 0 : ((longint'(rw - 1) * b.col) << 16) / (cfg_ow - 1);
        iy = py >> 16;
        ix = px >> 16;
        fy = py & 64'hFFFF;
        fx = px & 64'hFFFF;
        gy = 65536 - fy;
        gx = 65536 - fx;
        dy = (iy + 1 < rh) ? 1 : 0;
        dx = (ix + 1 < rw) ? 1 : 0;
        y0 = b.ys + iy;
        x0 = b.xs + ix;
        a[0] = cell_addr(b.chan, y0, x0);
        a[1] = cell_addr(b.chan, y0, x0 + dx);
        a[2] = cell_addr(b.chan, y0 + dy, x0);
        a[3] = cell_addr(b.chan, y0 + dy, x0 + dx);
        for (int k = 0; k < 4; k++)
            if (!feature_set[a[k]] && miss < 0) miss = a[k];
        top = gx * feature_mem[a[0]] + fx * feature_mem[a[1]];
        bot = gx * feature_mem[a[2]] + fx * feature_mem[a[3]];
        sum = gy * top + fy * bot;
        r = (sum + (64'sd1 <<< 31)) >>> 32;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        value = r[15:0];
    endfunction

    // drive one beat and record what it causes once accepted
    task automatic send_beat(input t_beat b, input bit typed = 0,
                             input bit [15:0] tv = 0, input bit te = 0);
        bit [15:0] v;
        bit e;
        int miss;
        while ($urandom_range(99) < snd_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= b.mode;
        i_s_tdata  <= {4'b0, b.ye, b.xe, b.ys, b.xs, b.smp, b.col, b.row, b.chan};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (b.mode == MODE_LOAD) begin
            if (b.chan < cap(cfg_cc, 16) && b.row < cap(cfg_mh, 64) &&
                b.col < cap(cfg_mw, 64)) begin
                feature_mem[cell_addr(b.chan, b.row, b.col)] = b.smp;
                feature_set[cell_addr(b.chan, b.row, b.col)] = 1'b1;
            end
        end else if (typed) begin
            pending_values.push_back('{tv, te});
        end else begin
            resample_value(b, v, e, miss);
            pending_values.push_back('{v, e});
        end
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // write enable stays high; the caller drops it after the last write
    task automatic write_reg(input t_cfg_idx idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[SIZE_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_MAP_H:    cfg_mh = val & 7'h7F;
            CFG_MAP_W:    cfg_mw = val & 7'h7F;
            CFG_OUT_H:    cfg_oh = val & 7'h7F;
            CFG_OUT_W:    cfg_ow = val & 7'h7F;
            CFG_CHAN_CNT: cfg_cc = val & 5'h1F;
            default: ;
        endcase
    endtask

    // one region edge pair, mostly inside a map of the given size, sometimes random
    function automatic void pick_span(input int unsigned lim, input int unsigned outn,
                                      output bit [6:0] s, output bit [6:0] e);
        int unsigned w;
        if (lim == 0 || $urandom_range(9) == 0) begin
            s = $urandom_range(64);
            e = $urandom_range(64);
            return;
        end
        if ($urandom_range(3) == 0 && outn >= 1 && outn <= lim) w = outn;
        else if ($urandom_range(15) == 0) w = $urandom_range(1, lim);
        else w = $urandom_range(1, lim < 8 ? lim : 8);
        s = $urandom_range(0, lim - w);
        e = s + w;
    endfunction

    // sample beat with its neighbors loaded first
    task automatic run_sample(inout int n);
        t_beat b;
        bit [15:0] v;
        bit e;
        int miss;
        int unsigned nc;
        nc = cap(cfg_cc, 16);
        b.mode = MODE_SAMPLE;
        b.smp  = $urandom;
        b.chan = ($urandom_range(9) == 0 || nc == 0) ? $urandom_range(15) : $urandom_range(nc - 1);
        b.row  = ($urandom_range(9) == 0 || cfg_oh == 0) ? $urandom_range(63)
                 : $urandom_range(cap(cfg_oh, 64) - 1);
        b.col  = ($urandom_range(9) == 0 || cfg_ow == 0) ? $urandom_range(63)
                 : $urandom_range(cap(cfg_ow, 64) - 1);
        pick_span(cap(cfg_mw, 64), cfg_ow, b.xs, b.xe);
        pick_span(cap(cfg_mh, 64), cfg_oh, b.ys, b.ye);
        forever begin
            resample_value(b, v, e, miss);
            if (miss < 0) break;
            send_beat('{MODE_LOAD, miss >> 12, (miss >> 6) & 63, miss & 63, $urandom,
                        $urandom, $urandom, $urandom, $urandom});
            n++;
        end
        send_beat(b);
        n++;
    endtask

    // directed rows against the reset settings
    t_row directed [] = '{
        '{'{MODE_LOAD,   15, 63, 63, 16'h7FFF, 0, 0, 0, 0}, 0, 0, 0},
        '{'{MODE_LOAD,    0,  0,  0, 16'h8000, 127, 127, 127, 127}, 0, 0, 0},
        '{'{MODE_LOAD,   15,  0,  0, 16'h0100, 0, 0, 0, 0}, 0, 0, 0},
        '{'{MODE_LOAD,   15,  0,  1, 16'hFF00, 0, 0, 0, 0}, 0, 0, 0},
        '{'{MODE_SAMPLE, 15,  6,  6, 16'hFFFF, 63, 63, 64, 64}, 1, 16'h7FFF, 0},
        '{'{MODE_SAMPLE,  0,  0,  0, 0, 0, 0, 1, 1}, 1, 16'h8000, 0},
        '{'{MODE_SAMPLE,  0,  7,  0, 0, 0, 0, 1, 1}, 1, 16'h0000, 1},
        '{'{MODE_SAMPLE,  0,  0,  7, 0, 0, 0, 1, 1}, 1, 16'h0000, 1},
        '{'{MODE_SAMPLE,  0, 63, 63, 0, 0, 0, 1, 1}, 1, 16'h0000, 1},
        '{'{MODE_SAMPLE,  0,  0,  0, 0, 5, 0, 5, 1}, 1, 16'h0000, 1},
        '{'{MODE_SAMPLE,  0,  0,  0, 0, 0, 10, 1, 3}, 1, 16'h0000, 1},
        '{'{MODE_SAMPLE, 15,  3,  3, 0, 0, 0, 2, 1}, 0, 0, 0},
        '{'{MODE_SAMPLE, 15,  0,  6, 0, 0, 0, 2, 1}, 0, 0, 0},
        '{'{MODE_SAMPLE, 15,  2,  4, 0, 63, 0, 65, 1}, 1, 16'h0000, 1}
    };

    // settings per random phase: map_h, map_w, out_h, out_w, channel_count
    int unsigned phase_cfg [6][5] = '{
        '{64, 64, 7, 7, 16}, '{8, 8, 1, 1, 1}, '{64, 64, 64, 64, 16},
        '{12, 16, 5, 3, 4}, '{1, 1, 1, 1, 1}, '{127, 100, 0, 2, 31}
    };

    // main sequence
    initial begin
        int n;
        int ph;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i])
            send_beat(directed[i].beat, directed[i].typed, directed[i].value, directed[i].err);
        n = 0;
        ph = -1;
        while (n < 1700) begin
            if (n / 285 != ph) begin
                ph = n / 285;
                drain();
                write_reg(CFG_MAP_H, phase_cfg[ph][0]);
                write_reg(CFG_MAP_W, phase_cfg[ph][1]);
                write_reg(CFG_OUT_H, phase_cfg[ph][2]);
                write_reg(CFG_OUT_W, phase_cfg[ph][3]);
                write_reg(CFG_CHAN_CNT, phase_cfg[ph][4]);
                i_cfg_we <= 1'b0;
            end
            case (n / 567)
                0: begin snd_idle = 8;  rcv_idle = 76; end
                1: begin snd_idle = 76; rcv_idle = 8;  end
                default: begin snd_idle = 0; rcv_idle = 0; end
            endcase
            if ($urandom_range(4) == 0) begin
                send_beat('{MODE_LOAD, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom});
                n++;
            end else begin
                run_sample(n);
            end
        end
        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls and field compare
    always @(posedge i_clk) begin
        t_result want;
        i_m_tready <= ($urandom_range(99) >= rcv_idle);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_values.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end else begin
                want = pending_values.pop_front();
                if (o_m_tdata !== want.value) begin
                    $error("out_value expected %h actual %h", want.value, o_m_tdata);
                    fail_count++;
                end
                if (o_m_tuser[0] !== want.err) begin
                    $error("roi_error expected %b actual %b", want.err, o_m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
